### hw/rtl/tic_pkg.sv
// Package: shared constants and types for the triangular inverse-CDF block.
`timescale 1ns / 1ps
`default_nettype none
package tic_pkg;
  localparam int SampleW = 16;
  localparam int ValW    = 16;
  localparam int SpanW   = 17;           // b-a fits in 17 bits unsigned
  localparam int ProdW   = 2 * SpanW;    // span*side
  localparam int RadW    = ProdW;        // (prod*u)>>16 stays below 2^34
  localparam int RootW   = RadW / 2;     // 17-bit root
  localparam int SqStages = RootW;

  localparam logic [1:0] RegLower = 2'd0;
  localparam logic [1:0] RegUpper = 2'd1;
  localparam logic [1:0] RegPeak  = 2'd2;

  typedef struct packed {
    logic              err;
    logic              low_arm;
    logic signed [ValW-1:0] base;
  } tic_side_t;
endpackage
`default_nettype wire

### hw/rtl/tic_front.sv
// Front stages: select the arm and form the radicand over three register stages.
`timescale 1ns / 1ps
`default_nettype none
module tic_front import tic_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire logic                   in_v,
  input  wire logic [SampleW-1:0]     samp,
  input  wire logic signed [ValW-1:0] lo_b,
  input  wire logic signed [ValW-1:0] hi_b,
  input  wire logic signed [ValW-1:0] pk_b,
  output logic                        out_v,
  output tic_side_t                   out_side,
  output logic [RadW-1:0]             out_rad
);
  // stage 1: differences, checks, compare
  logic v1_r;
  tic_side_t s1_r;
  logic [SpanW-1:0] span1_r, side1_r;
  logic [SampleW:0] w1_r;
  // stage 2: span*side
  logic v2_r;
  tic_side_t s2_r;
  logic [ProdW-1:0] p2_r;
  logic [SampleW:0] w2_r;
  // stage 3: radicand
  logic v3_r;
  tic_side_t s3_r;
  logic [RadW-1:0] r3_r;

  logic [SpanW-1:0] span, left, right;
  logic bad, low_arm;
  logic [SpanW+SampleW-1:0] lhs, rhs;
  logic [ProdW+SampleW:0] full;

  always_comb begin
    // widen before subtracting so a full-range difference does not wrap
    span  = SpanW'(hi_b) - SpanW'(lo_b);
    left  = SpanW'(pk_b) - SpanW'(lo_b);
    right = SpanW'(hi_b) - SpanW'(pk_b);
    bad   = (lo_b >= hi_b) || (pk_b < lo_b) || (pk_b > hi_b);
    lhs   = (SpanW+SampleW)'(samp) * (SpanW+SampleW)'(span);
    rhs   = {left, {SampleW{1'b0}}};
    low_arm = lhs < rhs;
    full  = (ProdW+SampleW+1)'(p2_r) * (ProdW+SampleW+1)'(w2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v; v2_r <= v1_r; v3_r <= v2_r;
    end
    if (adv) begin
      s1_r.err     <= bad;
      s1_r.low_arm <= low_arm;
      s1_r.base    <= low_arm ? lo_b : hi_b;
      span1_r      <= span;
      side1_r      <= low_arm ? left : right;
      w1_r         <= low_arm ? {1'b0, samp} : ((SampleW+1)'(1) << SampleW) - {1'b0, samp};
      s2_r <= s1_r;
      p2_r <= span1_r * side1_r;
      w2_r <= w1_r;
      s3_r <= s2_r;
      r3_r <= RadW'(full >> SampleW);
    end
  end

  assign out_v    = v3_r;
  assign out_side = s3_r;
  assign out_rad  = r3_r;
endmodule
`default_nettype wire

### hw/rtl/tic_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tic_sqrt import tic_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_v,
  input  tic_side_t             in_side,
  input  wire logic [RadW-1:0]  in_rad,
  output logic                  out_v,
  output tic_side_t             out_side,
  output logic [RootW-1:0]      out_root
);
  logic            v_r   [SqStages];
  tic_side_t       sd_r  [SqStages];
  logic [RadW-1:0] rem_r [SqStages];
  logic [RadW-1:0] rad_r [SqStages];
  logic [RootW-1:0] q_r  [SqStages];

  always_ff @(posedge clk) begin
    for (int k = 0; k < SqStages; k++) begin
      logic [RadW-1:0] rem_i, rad_i, trial, rem_s;
      logic [RootW-1:0] q_i;
      rem_i = (k == 0) ? '0 : rem_r[k-1 < 0 ? 0 : k-1];
      rad_i = (k == 0) ? in_rad : rad_r[k-1 < 0 ? 0 : k-1];
      q_i   = (k == 0) ? '0 : q_r[k-1 < 0 ? 0 : k-1];
      rem_s = {rem_i[RadW-3:0], rad_i[RadW-1 -: 2]};
      trial = {(RadW-RootW-2)'(0), q_i, 2'b01};
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= (k == 0) ? in_v : v_r[k-1 < 0 ? 0 : k-1];
      end
      if (adv) begin
        sd_r[k]  <= (k == 0) ? in_side : sd_r[k-1 < 0 ? 0 : k-1];
        rad_r[k] <= {rad_i[RadW-3:0], 2'b00};
        if (rem_s >= trial) begin
          rem_r[k] <= rem_s - trial;
          q_r[k]   <= {q_i[RootW-2:0], 1'b1};
        end else begin
          rem_r[k] <= rem_s;
          q_r[k]   <= {q_i[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v    = v_r[SqStages-1];
  assign out_side = sd_r[SqStages-1];
  assign out_root = q_r[SqStages-1];
endmodule
`default_nettype wire

### hw/rtl/triangular_inverse_cdf.sv
// Top level: triangular inverse-CDF variate generator.
`timescale 1ns / 1ps
`default_nettype none
// Maps a uniform Q0.16 word to a triangular Q8.8 variate with configured
// minimum, maximum and mode. Takes one word per cycle while in_stall is
// low; a word passes three front stages for compare and the two multiplies,
// 17 square-root stages and one output register. The whole pipeline advances
// together and holds as a unit when out_stall is high with a result waiting;
// empty stages hold too, so bubbles are not squeezed out. Bounds that are
// inconsistent give variate 0 with config_error set.
module triangular_inverse_cdf import tic_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [ValW-1:0]        cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SampleW-1:0]     in_uniform_sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [ValW-1:0]      out_variate,
  output logic                        out_config_error
);
  logic signed [ValW-1:0] lo_r, hi_r, pk_r;
  logic adv;
  logic fv, sv;
  tic_side_t fs, ss;
  logic [RadW-1:0] frad;
  logic [RootW-1:0] root;
  logic ov_r;
  logic signed [ValW-1:0] var_r;
  logic err_r;

  // advance whenever the output slot is free or is being taken
  assign adv      = !ov_r || !out_stall;
  assign in_stall = !adv;

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= 16'sd1024; hi_r <= 16'sd2048; pk_r <= 16'sd1792;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegLower: lo_r <= cfg_data;
        RegUpper: hi_r <= cfg_data;
        RegPeak:  pk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tic_front u_front (
    .clk, .rst_n, .adv, .in_v(in_valid), .samp(in_uniform_sample),
    .lo_b(lo_r), .hi_b(hi_r), .pk_b(pk_r),
    .out_v(fv), .out_side(fs), .out_rad(frad)
  );

  tic_sqrt u_sqrt (
    .clk, .rst_n, .adv, .in_v(fv), .in_side(fs), .in_rad(frad),
    .out_v(sv), .out_side(ss), .out_root(root)
  );

  // output register: add or subtract the root, or force zero on error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= sv;
    end
    if (adv) begin
      err_r <= ss.err;
      if (ss.err)
        var_r <= '0;
      else if (ss.low_arm)
        var_r <= ss.base + ValW'(root);
      else
        var_r <= ss.base - ValW'(root);
    end
  end

  assign out_valid        = ov_r;
  assign out_variate      = var_r;
  assign out_config_error = err_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_variate))
    else $error("result word lost under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_error |-> out_variate == '0)
    else $error("error result not zero");
endmodule
`default_nettype wire
